// File: hdl/mcsrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsrb_pkg
// Shared types, constants and helpers for the multi-channel sample ring buffer.
// ----------------------------------------------------------------------------
package mcsrb_pkg;

    localparam int DEF_MAX_DEPTH   = 64;
    localparam int DEF_LAYERS      = 6;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int SMP_W     = 32;  // sample field width on the ports
    localparam int DEPTH_W   = 7;   // depth, fill, requested and returned
    localparam int LAYER_W   = 3;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int GROUP_W   = 2;
    localparam int NUM_GROUPS = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_OLDEST = 2'd1,
        ACT_LATEST = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // depth register indexes, one per layer group
    localparam logic [GROUP_W-1:0] GRP_BVP    = 2'd0;
    localparam logic [GROUP_W-1:0] GRP_MOTION = 2'd1;
    localparam logic [GROUP_W-1:0] GRP_SKIN   = 2'd2;
    localparam logic [GROUP_W-1:0] GRP_TEMP   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;        // take the input item
        logic rd_first;    // read the first sample of a burst
        logic rd_next;     // step to and read the next sample
        logic sel_sample;  // output shows a sample from the store
    } t_dp_cmd;

    typedef struct packed {
        logic burst;       // incoming item is a read with something to return
        logic last;        // sample now shown is the final one
    } t_dp_sts;

    function automatic logic [GROUP_W-1:0] group_of(input logic [LAYER_W-1:0] layer);
        logic [GROUP_W-1:0] g;
        unique case (layer) inside
            3'd0:                 g = GRP_BVP;
            [3'd1:3'd3]:          g = GRP_MOTION;
            3'd4:                 g = GRP_SKIN;
            default:              g = GRP_TEMP;
        endcase
        return g;
    endfunction

    // depth in use: zero acts as one, anything above the ring size as the size
    function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] d,
                                                     input logic [DEPTH_W-1:0] maxd);
        logic [DEPTH_W-1:0] e;
        if (d == '0) begin
            e = DEPTH_W'(1);
        end else if (d > maxd) begin
            e = maxd;
        end else begin
            e = d;
        end
        return e;
    endfunction

endpackage

// File: hdl/mcsrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsrb_ctrl
// Item sequencer: accepts an item, runs the read burst and hands out results.
// ----------------------------------------------------------------------------
module mcsrb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  mcsrb_pkg::t_dp_sts i_sts,
    output mcsrb_pkg::t_dp_cmd o_cmd
);
    import mcsrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.burst ? ST_FETCH : ST_RESP;
                end
            end
            ST_FETCH: begin
                o_cmd.rd_first = 1'b1;
                n_state        = ST_SHOW;
            end
            ST_SHOW: begin
                o_out_valid      = 1'b1;
                o_cmd.sel_sample = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // next read lands in the data register with this transfer
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/mcsrb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsrb_dp
// Ring datapath: depth registers, per-layer pointers and fills, sample store.
// ----------------------------------------------------------------------------
module mcsrb_dp #(
    parameter int MAX_DEPTH   = mcsrb_pkg::DEF_MAX_DEPTH,
    parameter int LAYERS      = mcsrb_pkg::DEF_LAYERS,
    parameter int SAMPLE_BITS = mcsrb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mcsrb_pkg::t_dp_cmd                   i_cmd,
    output mcsrb_pkg::t_dp_sts                   o_sts,
    input  logic [mcsrb_pkg::ACTION_W-1:0]       i_action,
    input  logic [mcsrb_pkg::LAYER_W-1:0]        i_layer,
    input  logic signed [mcsrb_pkg::SMP_W-1:0]   i_sample,
    input  logic [mcsrb_pkg::DEPTH_W-1:0]        i_requested,
    input  logic                                 i_cfg_valid,
    input  logic [mcsrb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mcsrb_pkg::DEPTH_W-1:0]        i_cfg_data,
    output logic signed [mcsrb_pkg::SMP_W-1:0]   o_out_sample,
    output logic [mcsrb_pkg::DEPTH_W-1:0]        o_returned,
    output logic                                 o_last,
    output logic                                 o_no_data,
    output logic                                 o_status,
    output logic [mcsrb_pkg::DEPTH_W-1:0]        o_layer_fill,
    output logic                                 o_ready_res
);
    import mcsrb_pkg::*;

    localparam int PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LIW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int STW    = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
    localparam int MEM_DEPTH = LAYERS << PTR_W;
    localparam int SUM_W  = DEPTH_W + 1;
    localparam logic [DEPTH_W-1:0] MAXD = DEPTH_W'(MAX_DEPTH);
    localparam logic [LAYER_W:0]   NLAY = (LAYER_W + 1)'(LAYERS);

    logic [DEPTH_W-1:0] r_depth_reg [NUM_GROUPS];
    logic [PTR_W-1:0]   r_wp        [LAYERS];
    logic [DEPTH_W-1:0] r_fill      [LAYERS];

    logic signed [STW-1:0] r_mem [MEM_DEPTH];
    logic signed [STW-1:0] r_rdata;

    // item registers
    logic [LIW-1:0]     r_li;
    logic               r_status;
    logic               r_no_data;
    logic [DEPTH_W-1:0] r_n;
    logic [DEPTH_W-1:0] r_remain;
    logic [PTR_W-1:0]   r_pos;
    logic [DEPTH_W-1:0] r_depth;

    // ---- incoming item decode
    logic               layer_ok;
    logic [LIW-1:0]     li;
    logic [DEPTH_W-1:0] d;
    logic [DEPTH_W-1:0] cnt;
    logic [PTR_W-1:0]   wp;
    logic [PTR_W-1:0]   wp_c;
    logic [DEPTH_W-1:0] wp_inc;
    logic [PTR_W-1:0]   wp_nxt;
    logic [DEPTH_W-1:0] fill_nxt;
    logic [DEPTH_W-1:0] cnt_c;
    logic [DEPTH_W-1:0] n;
    logic [SUM_W-1:0]   start_sum;
    logic [SUM_W-1:0]   start_red;
    logic               is_read;
    logic               do_write;

    always_comb begin
        layer_ok = ({1'b0, i_layer} < NLAY);
        li       = i_layer[LIW-1:0];
        d        = eff_depth(r_depth_reg[group_of(i_layer)], MAXD);
        cnt      = layer_ok ? r_fill[li] : '0;
        wp       = layer_ok ? r_wp[li] : '0;
        wp_c     = (DEPTH_W'(wp) >= d) ? '0 : wp;
        wp_inc   = DEPTH_W'(wp_c) + DEPTH_W'(1);
        wp_nxt   = (wp_inc == d) ? '0 : wp_inc[PTR_W-1:0];
        fill_nxt = (cnt < d) ? cnt + DEPTH_W'(1) : d;
        cnt_c    = (cnt > d) ? d : cnt;
        n        = (cnt_c < i_requested) ? cnt_c : i_requested;
        is_read  = (i_action == ACT_OLDEST) || (i_action == ACT_LATEST);
        do_write = layer_ok && (i_action == ACT_WRITE);
        // wp + d - count stays below 2d, so one conditional subtract wraps it
        if (i_action == ACT_OLDEST) begin
            start_sum = SUM_W'(wp) + SUM_W'(d) - SUM_W'(cnt_c);
        end else begin
            start_sum = SUM_W'(wp) + SUM_W'(d) - SUM_W'(n);
        end
        start_red = (start_sum >= SUM_W'(d)) ? start_sum - SUM_W'(d) : start_sum;
        o_sts.burst = layer_ok && is_read && (n != '0);
        o_sts.last  = (r_remain == DEPTH_W'(1));
    end

    // ---- burst stepping
    logic [DEPTH_W-1:0] pos_inc;
    logic [PTR_W-1:0]   pos_nxt;

    always_comb begin
        pos_inc    = DEPTH_W'(r_pos) + DEPTH_W'(1);
        pos_nxt    = (pos_inc == r_depth) ? '0 : pos_inc[PTR_W-1:0];
    end

    // ---- per-layer state and depth registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_depth_reg[g] <= DEPTH_W'(64);
            end
            for (int i = 0; i < LAYERS; i++) begin
                r_wp[i]   <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (i_cmd.load && do_write) begin
                r_wp[li]   <= wp_nxt;
                r_fill[li] <= fill_nxt;
            end
            // a depth change flushes every layer of its group
            if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_GROUPS))) begin
                r_depth_reg[i_cfg_index[GROUP_W-1:0]] <= i_cfg_data;
                for (int i = 0; i < LAYERS; i++) begin
                    if (group_of(LAYER_W'(i)) == i_cfg_index[GROUP_W-1:0]) begin
                        r_wp[i]   <= '0;
                        r_fill[i] <= '0;
                    end
                end
            end
        end
    end

    // ---- item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_li      <= li;
            r_status  <= !layer_ok;
            r_no_data <= layer_ok && is_read && (n == '0);
            r_n       <= n;
            r_remain  <= n;
            r_pos     <= start_red[PTR_W-1:0];
            r_depth   <= d;
        end else if (i_cmd.rd_next) begin
            r_pos    <= pos_nxt;
            r_remain <= r_remain - DEPTH_W'(1);
        end
    end

    // ---- sample store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && do_write) begin
            r_mem[{li, wp_c}] <= i_sample[STW-1:0];
        end
        if (i_cmd.rd_first) begin
            r_rdata <= r_mem[{r_li, r_pos}];
        end else if (i_cmd.rd_next) begin
            r_rdata <= r_mem[{r_li, pos_nxt}];
        end
    end

    // ---- ready flag: every layer at least half full
    always_comb begin
        o_ready_res = 1'b1;
        for (int i = 0; i < LAYERS; i++) begin
            if (r_fill[i] < (eff_depth(r_depth_reg[group_of(LAYER_W'(i))], MAXD) >> 1)) begin
                o_ready_res = 1'b0;
            end
        end
    end

    // ---- result fields
    always_comb begin
        o_layer_fill = r_status ? '0 : r_fill[r_li];
        if (i_cmd.sel_sample) begin
            o_out_sample = SMP_W'(r_rdata);
            o_returned   = r_n;
            o_last       = o_sts.last;
            o_no_data    = 1'b0;
            o_status     = 1'b0;
        end else begin
            o_out_sample = '0;
            o_returned   = '0;
            o_last       = 1'b1;
            o_no_data    = r_no_data;
            o_status     = r_status;
        end
    end

endmodule

// File: hdl/multi_channel_sample_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_sample_ring_buffer
// Per-layer overwrite-when-full sample rings with oldest and latest readout.
// ----------------------------------------------------------------------------
// One item is handled at a time; the input is ready only while no result is
// pending. A write, an undefined action, an empty read or a bad layer gives a
// single result the cycle after the transfer. A read returning n samples first
// registers the item, then fetches on the single registered read port of the
// sample store, then gives one sample per cycle while the output does not
// stall, the next read issued with each output transfer. The store needs no
// clearing after reset: only entries written since the last flush of a layer
// are ever read. Writing a depth register flushes the layers of its group;
// the configuration port is always ready and is to be written only while no
// item is in progress.
// ----------------------------------------------------------------------------
module multi_channel_sample_ring_buffer #(
    parameter int MAX_DEPTH   = mcsrb_pkg::DEF_MAX_DEPTH,
    parameter int LAYERS      = mcsrb_pkg::DEF_LAYERS,
    parameter int SAMPLE_BITS = mcsrb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mcsrb_pkg::ACTION_W-1:0]     i_action,
    input  logic [mcsrb_pkg::LAYER_W-1:0]      i_layer,
    input  logic signed [mcsrb_pkg::SMP_W-1:0] i_sample,
    input  logic [mcsrb_pkg::DEPTH_W-1:0]      i_requested,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [mcsrb_pkg::SMP_W-1:0] o_out_sample,
    output logic [mcsrb_pkg::DEPTH_W-1:0]      o_returned,
    output logic                               o_last,
    output logic                               o_no_data,
    output logic                               o_status,
    output logic [mcsrb_pkg::DEPTH_W-1:0]      o_layer_fill,
    output logic                               o_ready_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mcsrb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcsrb_pkg::DEPTH_W-1:0]      i_cfg_data
);
    import mcsrb_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    mcsrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mcsrb_dp #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LAYERS      (LAYERS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_action),
        .i_layer      (i_layer),
        .i_sample     (i_sample),
        .i_requested  (i_requested),
        .i_cfg_valid  (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_sample (o_out_sample),
        .o_returned   (o_returned),
        .o_last       (o_last),
        .o_no_data    (o_no_data),
        .o_status     (o_status),
        .o_layer_fill (o_layer_fill),
        .o_ready_res  (o_ready_res)
    );

endmodule

// File: tb/multi_channel_sample_ring_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_sample_ring_buffer_tb
// Self-checking bench: queued write/read transfers drive the block while a
// behavioural copy of the six rings predicts every result. A short directed
// run is followed by random phases with different depth settings.
// ----------------------------------------------------------------------------
module multi_channel_sample_ring_buffer_tb;
    import mcsrb_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int LAYERS        = DEF_LAYERS;
    localparam int MAX_DEPTH     = DEF_MAX_DEPTH;

    localparam logic [CFG_IDX_W-1:0] CFG_BVP      = {1'b0, GRP_BVP};
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION   = {1'b0, GRP_MOTION};
    localparam logic [CFG_IDX_W-1:0] CFG_SKIN     = {1'b0, GRP_SKIN};
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP     = {1'b0, GRP_TEMP};
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        t_action                  action;
        logic [LAYER_W-1:0]       layer;
        logic signed [SMP_W-1:0]  word;
        logic [DEPTH_W-1:0]       req;
    } sensor_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0]  word;
        logic [DEPTH_W-1:0]       returned;
        logic                     last;
        logic                     no_data;
        logic                     status;
        logic [DEPTH_W-1:0]       fill;
        logic                     all_half;
    } ring_result_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_SPARSE
    } sink_mode_t;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     in_valid    = 1'b0;
    logic [ACTION_W-1:0]      in_action   = '0;
    logic [LAYER_W-1:0]       in_layer    = '0;
    logic signed [SMP_W-1:0]  in_word     = '0;
    logic [DEPTH_W-1:0]       in_req      = '0;
    logic                     out_ready   = 1'b0;
    logic                     cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [DEPTH_W-1:0]       cfg_data    = '0;

    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [SMP_W-1:0]  o_out_sample;
    logic [DEPTH_W-1:0]       o_returned;
    logic                     o_last;
    logic                     o_no_data;
    logic                     o_status;
    logic [DEPTH_W-1:0]       o_layer_fill;
    logic                     o_ready_res;
    logic                     o_cfg_ready;

    // predicted ring contents and configuration
    logic [SMP_W-1:0]         ring_mem [0:LAYERS-1][0:MAX_DEPTH-1];
    logic [5:0]               wr_ptr   [0:LAYERS-1];
    logic [DEPTH_W-1:0]       fill_cnt [0:LAYERS-1];
    logic [DEPTH_W-1:0]       depth_reg[0:NUM_GROUPS-1];

    sensor_item_t             queued_requests[$];
    ring_result_t             due_results[$];
    sensor_item_t             cur_item;
    int                       mismatch_count = 0;
    int                       burst_left = 0;
    int                       gap_left = 0;
    sink_mode_t               sink_mode = SINK_OPEN;
    int                       sink_span = 0;

    multi_channel_sample_ring_buffer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (in_action),
        .i_layer      (in_layer),
        .i_sample     (in_word),
        .i_requested  (in_req),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_sample (o_out_sample),
        .o_returned   (o_returned),
        .o_last       (o_last),
        .o_no_data    (o_no_data),
        .o_status     (o_status),
        .o_layer_fill (o_layer_fill),
        .o_ready_res  (o_ready_res),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [GROUP_W-1:0] depth_group(input int unsigned layer);
        logic [GROUP_W-1:0] g;
        if (layer == 0) begin
            g = GRP_BVP;
        end else if (layer <= 3) begin
            g = GRP_MOTION;
        end else if (layer == 4) begin
            g = GRP_SKIN;
        end else begin
            g = GRP_TEMP;
        end
        return g;
    endfunction

    function automatic int unsigned used_depth(input int unsigned layer);
        int unsigned raw;
        raw = depth_reg[depth_group(layer)];
        if (raw == 0) begin
            raw = 1;
        end else if (raw > MAX_DEPTH) begin
            raw = MAX_DEPTH;
        end
        return raw;
    endfunction

    function automatic logic all_half_full();
        logic ok;
        int   i;
        ok = 1'b1;
        for (i = 0; i < LAYERS; i++) begin
            if (fill_cnt[i] < used_depth(i) / 2) ok = 1'b0;
        end
        return ok;
    endfunction

    // a depth write flushes every layer of its group; spare indexes are ignored
    task automatic apply_depth(input logic [CFG_IDX_W-1:0] idx, input logic [DEPTH_W-1:0] val);
        int i;
        if (idx < NUM_GROUPS) begin
            depth_reg[idx[GROUP_W-1:0]] = val;
            for (i = 0; i < LAYERS; i++) begin
                if (depth_group(i) == idx[GROUP_W-1:0]) begin
                    wr_ptr[i]   = '0;
                    fill_cnt[i] = '0;
                end
            end
        end
    endtask

    task automatic predict_ring_access(input sensor_item_t it);
        ring_result_t r;
        int unsigned  d;
        int unsigned  cnt;
        int unsigned  n;
        int unsigned  wp;
        int unsigned  first;
        int unsigned  k;
        r = '0;
        r.last = 1'b1;
        if (it.layer >= LAYERS) begin
            r.status   = 1'b1;
            r.all_half = all_half_full();
            due_results.push_back(r);
        end else begin
            d   = used_depth(it.layer);
            cnt = fill_cnt[it.layer];
            wp  = wr_ptr[it.layer];
            if (it.action == ACT_WRITE) begin
                if (wp >= d) wp = 0;
                ring_mem[it.layer][wp] = it.word;
                wr_ptr[it.layer]   = 6'((wp + 1) % d);
                fill_cnt[it.layer] = DEPTH_W'((cnt < d) ? cnt + 1 : d);
                r.fill     = fill_cnt[it.layer];
                r.all_half = all_half_full();
                due_results.push_back(r);
            end else if (it.action == ACT_NONE) begin
                r.fill     = fill_cnt[it.layer];
                r.all_half = all_half_full();
                due_results.push_back(r);
            end else begin
                if (cnt > d) cnt = d;
                n = (cnt < it.req) ? cnt : it.req;
                r.fill     = fill_cnt[it.layer];
                r.all_half = all_half_full();
                if (n == 0) begin
                    r.no_data = 1'b1;
                    due_results.push_back(r);
                end else begin
                    // oldest starts at the tail of the ring, latest n back from the head
                    if (it.action == ACT_OLDEST) begin
                        first = (wp + d - cnt) % d;
                    end else begin
                        first = (wp + d - n) % d;
                    end
                    r.returned = DEPTH_W'(n);
                    for (k = 0; k < n; k++) begin
                        r.word = ring_mem[it.layer][(first + k) % d];
                        r.last = (k + 1 == n);
                        due_results.push_back(r);
                    end
                end
            end
        end
    endtask

    function automatic sensor_item_t make_item(input t_action act, input int unsigned layer,
                                               input logic [SMP_W-1:0] word,
                                               input int unsigned req);
        sensor_item_t it;
        it.action = act;
        it.layer  = LAYER_W'(layer);
        it.word   = word;
        it.req    = DEPTH_W'(req);
        return it;
    endfunction

    // mostly writes and reads on valid layers; a few undefined actions and bad layers
    function automatic sensor_item_t random_item(input int focus);
        sensor_item_t it;
        int unsigned  pick;
        pick     = $urandom_range(0, 99);
        it.word  = $urandom;
        it.req   = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom_range(0, 127))
                                               : DEPTH_W'($urandom_range(0, 10));
        it.layer = (focus >= 0 && $urandom_range(0, 5) != 0) ? LAYER_W'(focus)
                                                             : LAYER_W'($urandom_range(0, 5));
        if (pick < 6) begin
            it.action = t_action'($urandom_range(0, 3));
            it.layer  = LAYER_W'($urandom_range(0, 7));
        end else if (pick < 62) begin
            it.action = ACT_WRITE;
        end else if (pick < 81) begin
            it.action = ACT_OLDEST;
        end else begin
            it.action = ACT_LATEST;
        end
        return it;
    endfunction

    task automatic write_depth(input logic [CFG_IDX_W-1:0] idx, input logic [DEPTH_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_depth(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_depths(input int unsigned bvp, input int unsigned motion,
                              input int unsigned skin, input int unsigned temp);
        write_depth(CFG_BVP,    DEPTH_W'(bvp));
        write_depth(CFG_MOTION, DEPTH_W'(motion));
        write_depth(CFG_SKIN,   DEPTH_W'(skin));
        write_depth(CFG_TEMP,   DEPTH_W'(temp));
    endtask

    task automatic settle();
        while (queued_requests.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [SMP_W-1:0] want,
                                 input logic [SMP_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // request driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_ring_access(cur_item);
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    cur_item = queued_requests.pop_front();
                    in_valid  <= 1'b1;
                    in_action <= cur_item.action;
                    in_layer  <= cur_item.layer;
                    in_word   <= cur_item.word;
                    in_req    <= cur_item.req;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge i_clk) begin
        ring_result_t want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing expected: sample %0h fill %0d",
                           o_out_sample, o_layer_fill);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("out_sample", want.word, o_out_sample);
                    compare_field("returned", SMP_W'(want.returned), SMP_W'(o_returned));
                    compare_field("last", SMP_W'(want.last), SMP_W'(o_last));
                    compare_field("no_data", SMP_W'(want.no_data), SMP_W'(o_no_data));
                    compare_field("status", SMP_W'(want.status), SMP_W'(o_status));
                    compare_field("layer_fill", SMP_W'(want.fill), SMP_W'(o_layer_fill));
                    compare_field("ready_res", SMP_W'(want.all_half), SMP_W'(o_ready_res));
                end
            end
            if (sink_span == 0) begin
                sink_mode = sink_mode_t'($urandom_range(0, 2));
                sink_span = $urandom_range(20, 80);
            end else begin
                sink_span--;
            end
            case (sink_mode)
                SINK_OPEN:   out_ready <= 1'b1;
                SINK_RANDOM: out_ready <= 1'($urandom_range(0, 1));
                default:     out_ready <= (sink_span % 4 == 0);
            endcase
        end
    end

    initial begin
        int ph;
        int focus;
        int count;
        int k;
        for (k = 0; k < LAYERS; k++) begin
            wr_ptr[k]   = '0;
            fill_cnt[k] = '0;
        end
        for (k = 0; k < NUM_GROUPS; k++) depth_reg[k] = DEPTH_W'(MAX_DEPTH);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty rings, sample extremes, oversized and zero requests, bad layers
        queued_requests.push_back(make_item(ACT_OLDEST, 0, '0, 5));
        queued_requests.push_back(make_item(ACT_LATEST, 2, '0, 0));
        queued_requests.push_back(make_item(ACT_WRITE, 0, 32'h7fff_ffff, 0));
        queued_requests.push_back(make_item(ACT_WRITE, 0, 32'h8000_0000, 127));
        queued_requests.push_back(make_item(ACT_WRITE, 0, 32'h0000_0000, 64));
        queued_requests.push_back(make_item(ACT_WRITE, 0, 32'hffff_ffff, 1));
        queued_requests.push_back(make_item(ACT_OLDEST, 0, '0, 64));
        queued_requests.push_back(make_item(ACT_LATEST, 0, '1, 2));
        queued_requests.push_back(make_item(ACT_OLDEST, 0, '0, 0));
        queued_requests.push_back(make_item(ACT_LATEST, 0, '0, 127));
        queued_requests.push_back(make_item(ACT_NONE, 0, '1, 3));
        queued_requests.push_back(make_item(ACT_NONE, 7, '0, 3));
        queued_requests.push_back(make_item(ACT_WRITE, 6, $urandom, 0));
        queued_requests.push_back(make_item(ACT_OLDEST, 7, '0, 3));
        for (k = 1; k < LAYERS; k++)
            queued_requests.push_back(make_item(ACT_WRITE, k, $urandom, 0));
        queued_requests.push_back(make_item(ACT_OLDEST, 5, '0, 1));
        settle();

        // zero acts as one, above the ring size acts as the size; spare indexes ignored
        set_depths(2, 0, 127, 3);
        write_depth(CFG_SPARE_LO, 7'd127);
        write_depth(CFG_SPARE_HI, 7'd0);
        for (k = 0; k < 3; k++)
            queued_requests.push_back(make_item(ACT_WRITE, 0, $urandom, 0));
        queued_requests.push_back(make_item(ACT_OLDEST, 0, '0, 64));
        queued_requests.push_back(make_item(ACT_LATEST, 0, '0, 1));
        queued_requests.push_back(make_item(ACT_WRITE, 1, $urandom, 0));
        queued_requests.push_back(make_item(ACT_WRITE, 1, $urandom, 0));
        queued_requests.push_back(make_item(ACT_LATEST, 1, '0, 5));
        settle();

        for (ph = 0; ph < 6; ph++) begin
            focus = -1;
            count = 40;
            case (ph)
                0: set_depths(1, 1, 1, 1);
                1: set_depths(64, 0, 127, 1);
                2: begin
                    set_depths($urandom_range(1, 8), $urandom_range(1, 8),
                               $urandom_range(1, 8), $urandom_range(1, 8));
                    count = 50;
                end
                3: begin
                    set_depths($urandom_range(2, 6), $urandom_range(2, 6),
                               $urandom_range(2, 6), $urandom_range(2, 6));
                    count = 50;
                end
                4: begin
                    // fill one layer past a full ring so it wraps, then full-depth reads
                    set_depths(64, 64, 64, 64);
                    for (k = 0; k < 70; k++)
                        queued_requests.push_back(make_item(ACT_WRITE, 0, $urandom, 0));
                    focus = 0;
                end
                default: set_depths($urandom_range(0, 127), $urandom_range(0, 127),
                                    $urandom_range(0, 127), $urandom_range(0, 127));
            endcase
            for (k = 0; k < count; k++) queued_requests.push_back(random_item(focus));
            settle();
        end

        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
